// ===== hdl/lsic_pkg.sv =====
// ----------------------------------------------------------------------------
// lsic_pkg: shared types and constants
// Widths, register indexes, group codes and payload structs for the lane
// segment intercept classifier.
// ----------------------------------------------------------------------------
package lsic_pkg;

  localparam int MAX_SEGMENTS = 1023;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int YOUT_W  = 10;
  localparam int GROUP_W = 3;
  localparam int MEAN_W  = 28;
  localparam int CNT_W   = 10;
  localparam int MARG_W  = 24;
  localparam int Q_FRAC  = 8;
  localparam int MIN_ROWS = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int ACC_W      = 40;
  localparam int DIV_W      = ACC_W;
  localparam int DVS_W      = CNT_W + 1;
  localparam int DIV_DIGIT  = 2;
  localparam int DIV_STEPS  = DIV_W / DIV_DIGIT;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int MUL_STEPS  = COL_W;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS + 1);

  localparam logic [CNT_W-1:0] COUNT_LIMIT =
    CNT_W'((MAX_SEGMENTS > 1023) ? 1023 : MAX_SEGMENTS);

  localparam logic [MARG_W-1:0] MARGIN_RST = MARG_W'(2560);

  localparam logic signed [MEAN_W-1:0] INT_MAX_C = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic signed [MEAN_W-1:0] INT_MIN_C = {1'b1, {(MEAN_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_MARGIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MARGIN = 2'd2;

  localparam logic [GROUP_W-1:0] GRP_FLAT     = 3'd0;
  localparam logic [GROUP_W-1:0] GRP_VERT     = 3'd1;
  localparam logic [GROUP_W-1:0] GRP_L_FIRST  = 3'd2;
  localparam logic [GROUP_W-1:0] GRP_L_SECOND = 3'd3;
  localparam logic [GROUP_W-1:0] GRP_L_NONE   = 3'd4;
  localparam logic [GROUP_W-1:0] GRP_R_FIRST  = 3'd5;
  localparam logic [GROUP_W-1:0] GRP_R_SECOND = 3'd6;
  localparam logic [GROUP_W-1:0] GRP_R_NONE   = 3'd7;

  typedef struct packed {
    logic             frame_start;
    logic [COL_W-1:0] ax;
    logic [ROW_W-1:0] ay;
    logic [COL_W-1:0] bx;
    logic [ROW_W-1:0] by;
  } in_item_t;

  typedef struct packed {
    logic [GROUP_W-1:0]       group;
    logic [COL_W-1:0]         out_ax;
    logic [YOUT_W-1:0]        out_ay;
    logic [COL_W-1:0]         out_bx;
    logic [YOUT_W-1:0]        out_by;
    logic signed [MEAN_W-1:0] intercept;
    logic [CNT_W-1:0]         group_count;
  } out_item_t;

endpackage

// ===== hdl/lsic_div.sv =====
// ----------------------------------------------------------------------------
// lsic_div: serial unsigned divider
// Restoring division, DIV_DIGIT quotient bits per cycle, quotient shifted
// into the dividend register. done pulses when the quotient is final.
// ----------------------------------------------------------------------------
module lsic_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lsic_pkg::DIV_W-1:0] dividend,
  input  logic [lsic_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [lsic_pkg::DIV_W-1:0] quotient
);
  import lsic_pkg::*;

  logic [DIV_W-1:0]     q_r, q_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;

  always_comb begin
    logic [DVS_W:0] trial;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    for (int k = 0; k < DIV_DIGIT; k++) begin
      trial = {rem_nxt, q_nxt[DIV_W-1]};
      q_nxt = {q_nxt[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        trial    = trial - {1'b0, dvs_r};
        q_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == DIV_CNT_W'(1));
      if (start) begin
        cnt_r <= DIV_CNT_W'(DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== hdl/lane_segment_intercept_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// lane_segment_intercept_classifier_unit
// Classifies line segments into left/right lane groups by Q8 y-intercept and
// keeps a count and running mean of intercepts per group.
//
//   channel | signals                        | transfer when
//   --------+--------------------------------+---------------------------
//   input   | in_valid, in_ready, in_data    | in_valid & in_ready
//   result  | out_valid, out_ready, out_data | out_valid & out_ready
//   config  | cfg_we, cfg_index, cfg_data    | cfg_we
//
// Flat and vertical segments go straight to the output state. Classified
// segments use a bit-serial cross product and a serial division (2 quotient
// bits per cycle over 40 bits) for the intercept, and when a group is joined
// another multiply and division for its mean. One segment is in flight at a
// time; the next is taken while the result waits in the output register.
// Synchronous reset restores config defaults and clears groups.
// ----------------------------------------------------------------------------
module lane_segment_intercept_classifier_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lsic_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lsic_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [lsic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsic_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsic_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_MUL1 = 13'b0000000000010,
    S_LD1  = 13'b0000000000100,
    S_DIV1 = 13'b0000000001000,
    S_SAT  = 13'b0000000010000,
    S_CMP1 = 13'b0000000100000,
    S_CMP2 = 13'b0000001000000,
    S_MUL2 = 13'b0000010000000,
    S_ADD  = 13'b0000100000000,
    S_LD2  = 13'b0001000000000,
    S_DIV2 = 13'b0010000000000,
    S_UPD  = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [ROW_W-1:0]  row_offset_r;
  logic [MARG_W-1:0] left_margin_r, right_margin_r;

  logic [CNT_W-1:0]         grp_cnt_r  [4];
  logic [CNT_W-1:0]         grp_cnt_nxt[4];
  logic signed [MEAN_W-1:0] grp_mean_r  [4];
  logic signed [MEAN_W-1:0] grp_mean_nxt[4];

  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic [COL_W-1:0]         ax_r, ax_nxt, bx_r, bx_nxt, dxmag_r, dxmag_nxt;
  logic [YOUT_W-1:0]        y1_r, y1_nxt, y2_r, y2_nxt;
  logic                     left_r, left_nxt, dxneg_r, dxneg_nxt, qneg_r, qneg_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [COL_W-1:0]         mqa_r, mqa_nxt, mqb_r, mqb_nxt;
  logic [MUL_CNT_W-1:0]     mcnt_r, mcnt_nxt;
  logic signed [MEAN_W-1:0] b_r, b_nxt;
  logic [1:0]               gidx_r, gidx_nxt;
  logic [GROUP_W-1:0]       grp_r, grp_nxt;
  logic [CNT_W-1:0]         gcnt_out_r, gcnt_out_nxt;

  logic [YOUT_W-1:0]        y1_in, y2_in;
  logic signed [YOUT_W:0]   dy_in, dx_in;
  logic [YOUT_W:0]          dy_abs;
  logic                     flat_in, vert_in;

  logic signed [ACC_W-1:0]  mul_a, mul_b, acc_step;
  logic [ACC_W-1:0]         acc_abs;

  logic [CNT_W-1:0]         cnt_sel, cnt_inc;
  logic signed [MEAN_W-1:0] mean_sel;
  logic [MARG_W-1:0]        margin_sel;
  logic signed [MEAN_W:0]   diff;
  logic [MEAN_W:0]          diff_abs;
  logic                     match;

  logic                     div_start, div_done;
  logic [DIV_W-1:0]         div_dividend, div_q;
  logic [DVS_W-1:0]         div_divisor;
  logic                     big_pos, big_neg;

  // front-end classification on the incoming item
  assign y1_in   = {1'b0, in_data.ay} + {1'b0, row_offset_r};
  assign y2_in   = {1'b0, in_data.by} + {1'b0, row_offset_r};
  assign dy_in   = $signed({1'b0, y1_in}) - $signed({1'b0, y2_in});
  assign dx_in   = $signed({1'b0, in_data.ax}) - $signed({1'b0, in_data.bx});
  assign dy_abs  = dy_in[YOUT_W] ? YOUT_W'(1) + ~dy_in : dy_in;
  assign flat_in = dy_abs < (YOUT_W + 1)'(MIN_ROWS);
  assign vert_in = (in_data.ax == in_data.bx);

  // bit-serial multiply: MSB first, subtract term used for the cross product
  assign mul_a = (state_r == S_MUL1) ?
                 $signed({{(ACC_W-YOUT_W){1'b0}}, y2_r}) :
                 $signed({{(ACC_W-MEAN_W){mean_sel[MEAN_W-1]}}, mean_sel});
  assign mul_b = $signed({{(ACC_W-YOUT_W){1'b0}}, y1_r});
  assign acc_step = $signed({acc_r[ACC_W-2:0], 1'b0})
                  + (mqa_r[COL_W-1] ? mul_a : '0)
                  - (mqb_r[COL_W-1] ? mul_b : '0);
  assign acc_abs = acc_r[ACC_W-1] ? ('0 - acc_r) : acc_r;

  // group match test
  assign cnt_sel    = grp_cnt_r[gidx_r];
  assign mean_sel   = grp_mean_r[gidx_r];
  assign margin_sel = left_r ? left_margin_r : right_margin_r;
  assign diff       = $signed({b_r[MEAN_W-1], b_r}) - $signed({mean_sel[MEAN_W-1], mean_sel});
  assign diff_abs   = diff[MEAN_W] ? ('0 - diff) : diff;
  assign match      = (cnt_sel == '0) ||
                      (diff_abs < {{(MEAN_W+1-MARG_W){1'b0}}, margin_sel});
  assign cnt_inc    = (cnt_sel < COUNT_LIMIT) ? cnt_sel + CNT_W'(1) : cnt_sel;

  // divider hookup
  assign div_start    = (state_r == S_LD1) || (state_r == S_LD2);
  assign div_dividend = (state_r == S_LD1) ? {acc_abs[ACC_W-Q_FRAC-1:0], {Q_FRAC{1'b0}}}
                                           : acc_abs;
  assign div_divisor  = (state_r == S_LD1) ? {1'b0, dxmag_r}
                                           : {1'b0, cnt_sel} + DVS_W'(1);
  assign big_pos = div_q > {{(DIV_W-MEAN_W){1'b0}}, INT_MAX_C};
  assign big_neg = div_q > {{(DIV_W-MEAN_W){1'b0}}, INT_MIN_C};

  lsic_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    grp_cnt_nxt   = grp_cnt_r;
    grp_mean_nxt  = grp_mean_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ax_nxt        = ax_r;
    bx_nxt        = bx_r;
    y1_nxt        = y1_r;
    y2_nxt        = y2_r;
    dxmag_nxt     = dxmag_r;
    left_nxt      = left_r;
    dxneg_nxt     = dxneg_r;
    qneg_nxt      = qneg_r;
    acc_nxt       = acc_r;
    mqa_nxt       = mqa_r;
    mqb_nxt       = mqb_r;
    mcnt_nxt      = mcnt_r;
    b_nxt         = b_r;
    gidx_nxt      = gidx_r;
    grp_nxt       = grp_r;
    gcnt_out_nxt  = gcnt_out_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.frame_start) begin
            for (int i = 0; i < 4; i++) begin
              grp_cnt_nxt[i]  = '0;
              grp_mean_nxt[i] = '0;
            end
          end
          ax_nxt       = in_data.ax;
          bx_nxt       = in_data.bx;
          y1_nxt       = y1_in;
          y2_nxt       = y2_in;
          left_nxt     = dy_in[YOUT_W] != dx_in[YOUT_W];
          dxneg_nxt    = dx_in[YOUT_W];
          dxmag_nxt    = dx_in[YOUT_W] ? COL_W'(-dx_in) : dx_in[COL_W-1:0];
          b_nxt        = '0;
          gcnt_out_nxt = '0;
          acc_nxt      = '0;
          mqa_nxt      = in_data.ax;
          mqb_nxt      = in_data.bx;
          mcnt_nxt     = MUL_CNT_W'(MUL_STEPS);
          if (flat_in) begin
            grp_nxt   = GRP_FLAT;
            state_nxt = S_OUT;
          end else if (vert_in) begin
            grp_nxt   = GRP_VERT;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1, S_MUL2: begin
        acc_nxt  = acc_step;
        mqa_nxt  = {mqa_r[COL_W-2:0], 1'b0};
        mqb_nxt  = {mqb_r[COL_W-2:0], 1'b0};
        mcnt_nxt = mcnt_r - MUL_CNT_W'(1);
        if (mcnt_r == MUL_CNT_W'(1)) begin
          state_nxt = (state_r == S_MUL1) ? S_LD1 : S_ADD;
        end
      end
      S_LD1: begin
        qneg_nxt  = acc_r[ACC_W-1] ^ dxneg_r;
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        if (div_done) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        if (qneg_r) begin
          b_nxt = big_neg ? INT_MIN_C : $signed('0 - div_q[MEAN_W-1:0]);
        end else begin
          b_nxt = big_pos ? INT_MAX_C : $signed(div_q[MEAN_W-1:0]);
        end
        gidx_nxt  = {~left_r, 1'b0};
        state_nxt = S_CMP1;
      end
      S_CMP1, S_CMP2: begin
        if (match) begin
          acc_nxt   = '0;
          mqa_nxt   = cnt_sel;
          mqb_nxt   = '0;
          mcnt_nxt  = MUL_CNT_W'(MUL_STEPS);
          state_nxt = S_MUL2;
        end else if (state_r == S_CMP1) begin
          gidx_nxt  = {gidx_r[1], 1'b1};
          state_nxt = S_CMP2;
        end else begin
          grp_nxt   = left_r ? GRP_L_NONE : GRP_R_NONE;
          state_nxt = S_OUT;
        end
      end
      S_ADD: begin
        acc_nxt   = acc_r + $signed({{(ACC_W-MEAN_W){b_r[MEAN_W-1]}}, b_r});
        state_nxt = S_LD2;
      end
      S_LD2: begin
        qneg_nxt  = acc_r[ACC_W-1];
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        if (div_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        grp_mean_nxt[gidx_r] = qneg_r ? $signed('0 - div_q[MEAN_W-1:0])
                                      : $signed(div_q[MEAN_W-1:0]);
        grp_cnt_nxt[gidx_r]  = cnt_inc;
        gcnt_out_nxt         = cnt_inc;
        if (left_r) begin
          grp_nxt = gidx_r[0] ? GRP_L_SECOND : GRP_L_FIRST;
        end else begin
          grp_nxt = gidx_r[0] ? GRP_R_SECOND : GRP_R_FIRST;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.group       = grp_r;
          out_data_nxt.out_ax      = ax_r;
          out_data_nxt.out_ay      = y1_r;
          out_data_nxt.out_bx      = bx_r;
          out_data_nxt.out_by      = y2_r;
          out_data_nxt.intercept   = b_r;
          out_data_nxt.group_count = gcnt_out_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      row_offset_r   <= '0;
      left_margin_r  <= MARGIN_RST;
      right_margin_r <= MARGIN_RST;
      for (int i = 0; i < 4; i++) begin
        grp_cnt_r[i]  <= '0;
        grp_mean_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      grp_cnt_r   <= grp_cnt_nxt;
      grp_mean_r  <= grp_mean_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ROW_OFFSET:   row_offset_r   <= cfg_data[ROW_W-1:0];
          REG_LEFT_MARGIN:  left_margin_r  <= cfg_data[MARG_W-1:0];
          REG_RIGHT_MARGIN: right_margin_r <= cfg_data[MARG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    ax_r       <= ax_nxt;
    bx_r       <= bx_nxt;
    y1_r       <= y1_nxt;
    y2_r       <= y2_nxt;
    dxmag_r    <= dxmag_nxt;
    left_r     <= left_nxt;
    dxneg_r    <= dxneg_nxt;
    qneg_r     <= qneg_nxt;
    acc_r      <= acc_nxt;
    mqa_r      <= mqa_nxt;
    mqb_r      <= mqb_nxt;
    mcnt_r     <= mcnt_nxt;
    b_r        <= b_nxt;
    gidx_r     <= gidx_nxt;
    grp_r      <= grp_nxt;
    gcnt_out_r <= gcnt_out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider done outside a divide state");

  a_early_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.group == GRP_FLAT || out_data_r.group == GRP_VERT)
      |-> (out_data_r.intercept == '0 && out_data_r.group_count == '0))
    else $error("dropped segment carries intercept or count");

  a_join_counts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |=> gcnt_out_r != '0)
    else $error("joined group reports zero count");

endmodule
